// ----- hw/rtl/tbet_pkg.sv -----
// Shared types and constants of the touch button event table.
`default_nettype none

package tbet_pkg;

   localparam int ACTION_W = 2;
   localparam int COORD_W  = 12;
   localparam int EDGE_W   = 13;
   localparam int EVENT_W  = 2;
   localparam int SLOT_W   = 4;

   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [EVENT_W-1:0] EV_ADDED    = 2'd0;
   localparam logic [EVENT_W-1:0] EV_FULL     = 2'd1;
   localparam logic [EVENT_W-1:0] EV_PRESSED  = 2'd2;
   localparam logic [EVENT_W-1:0] EV_RELEASED = 2'd3;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SAMPLE,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type              kind;
      logic [COORD_W-1:0]  pos_x;
      logic [COORD_W-1:0]  pos_y;
      logic [EDGE_W-1:0]   right_edge;
      logic [EDGE_W-1:0]   bottom_edge;
      logic                touching;
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0]  left_edge;
      logic [COORD_W-1:0]  top_edge;
      logic [EDGE_W-1:0]   right_edge;
      logic [EDGE_W-1:0]   bottom_edge;
   } rect_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_TAIL,
      ST_FINISH
   } back_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tbet_front.sv -----
// Front end: accepts items, decodes the action, forms edges and queues commands.
`default_nettype none

module tbet_front
   import tbet_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [COORD_W-1:0]   req_pos_x,
   input  wire logic [COORD_W-1:0]   req_pos_y,
   input  wire logic [COORD_W-1:0]   req_width,
   input  wire logic [COORD_W-1:0]   req_height,
   input  wire logic                 req_touching,
   output logic                      q_valid,
   output cmd_type                   q_cmd,
   input  wire logic                 q_pop
);

   cmd_type              q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff;
   logic [Q_CNT_W-1:0]   cnt_in;
   cmd_type              dec_cmd;
   logic                 dec_keep;
   logic                 push;
   logic                 pop;

   always_comb begin
      dec_cmd.pos_x       = req_pos_x;
      dec_cmd.pos_y       = req_pos_y;
      dec_cmd.right_edge  = {1'b0, req_pos_x} + {1'b0, req_width};
      dec_cmd.bottom_edge = {1'b0, req_pos_y} + {1'b0, req_height};
      dec_cmd.touching    = req_touching;
      dec_cmd.kind        = OP_ADD;
      dec_keep            = 1'b1;
      case (req_action)
         ACT_ADD: begin
            dec_cmd.kind = OP_ADD;
         end
         ACT_SAMPLE: begin
            dec_cmd.kind = OP_SAMPLE;
         end
         ACT_CLEAR: begin
            dec_cmd.kind = OP_CLEAR;
         end
         default: begin
            dec_keep = 1'b0;
         end
      endcase
   end

   assign busy    = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_cmd   = q_ff[rd_ptr_ff];
   assign push    = start && !busy && dec_keep;
   assign pop     = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tbet_back.sv -----
// Back end: walks the slot table to add buttons and to turn touch samples into events, and clears the table.
`default_nettype none

module tbet_back
   import tbet_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire cmd_type              q_cmd,
   output logic                      q_pop,
   output logic                      rsp_valid,
   output logic [EVENT_W-1:0]        rsp_event_res,
   output logic [SLOT_W-1:0]         rsp_slot,
   output logic                      rsp_last
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   back_state_type       state_ff;
   back_state_type       state_in;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     idx_in;
   cmd_type              cur_ff;
   cmd_type              cur_in;
   logic [SLOTS-1:0]     used_ff;
   logic [SLOTS-1:0]     used_in;
   logic [SLOTS-1:0]     touched_ff;
   logic [SLOTS-1:0]     touched_in;
   logic                 rd_vld_ff;
   logic                 rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff;
   rect_type             rd_q_ff;
   logic                 pend_vld_ff;
   logic                 pend_vld_in;
   logic [EVENT_W-1:0]   pend_ev_ff;
   logic [EVENT_W-1:0]   pend_ev_in;
   logic [IDX_W-1:0]     pend_idx_ff;
   logic [IDX_W-1:0]     pend_idx_in;
   logic                 rsp_vld_ff;
   logic                 rsp_vld_in;
   logic [EVENT_W-1:0]   rsp_ev_ff;
   logic [EVENT_W-1:0]   rsp_ev_in;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic [IDX_W-1:0]     rsp_idx_in;
   logic                 rsp_last_ff;
   logic                 rsp_last_in;
   rect_type             mem [SLOTS];
   logic                 mem_we;
   rect_type             mem_wdata;
   logic                 free_here;
   logic                 now_touched;
   logic                 changed;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   assign free_here = !used_ff[idx_ff];

   assign now_touched = cur_ff.touching
                     && (cur_ff.pos_x > rd_q_ff.left_edge)
                     && ({1'b0, cur_ff.pos_x} < rd_q_ff.right_edge)
                     && (cur_ff.pos_y > rd_q_ff.top_edge)
                     && ({1'b0, cur_ff.pos_y} < rd_q_ff.bottom_edge);

   assign changed = rd_vld_ff && used_ff[rd_idx_ff]
                 && (now_touched != touched_ff[rd_idx_ff]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.kind)
                  OP_ADD: begin
                     state_in = ST_ADD;
                  end
                  OP_SAMPLE: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (free_here || (idx_ff == LAST_IDX)) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop       = 1'b0;
      idx_in      = idx_ff;
      cur_in      = cur_ff;
      used_in     = used_ff;
      touched_in  = touched_ff;
      rd_vld_in   = 1'b0;
      pend_vld_in = pend_vld_ff;
      pend_ev_in  = pend_ev_ff;
      pend_idx_in = pend_idx_ff;
      rsp_vld_in  = 1'b0;
      rsp_ev_in   = rsp_ev_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_last_in = rsp_last_ff;
      mem_we      = 1'b0;
      mem_wdata.left_edge   = cur_ff.pos_x;
      mem_wdata.top_edge    = cur_ff.pos_y;
      mem_wdata.right_edge  = cur_ff.right_edge;
      mem_wdata.bottom_edge = cur_ff.bottom_edge;

      case (state_ff)
         ST_IDLE: begin
            idx_in      = '0;
            pend_vld_in = 1'b0;
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_cmd;
               if (q_cmd.kind == OP_CLEAR) begin
                  used_in    = '0;
                  touched_in = '0;
               end
            end
         end
         ST_ADD: begin
            if (free_here) begin
               mem_we              = 1'b1;
               used_in[idx_ff]     = 1'b1;
               touched_in[idx_ff]  = 1'b0;
               rsp_vld_in          = 1'b1;
               rsp_ev_in           = EV_ADDED;
               rsp_idx_in          = idx_ff;
               rsp_last_in         = 1'b1;
            end else if (idx_ff == LAST_IDX) begin
               rsp_vld_in  = 1'b1;
               rsp_ev_in   = EV_FULL;
               rsp_idx_in  = '0;
               rsp_last_in = 1'b1;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            if (idx_ff != LAST_IDX) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
            if (pend_vld_ff) begin
               rsp_vld_in  = 1'b1;
               rsp_ev_in   = pend_ev_ff;
               rsp_idx_in  = pend_idx_ff;
               rsp_last_in = 1'b1;
            end
            pend_vld_in = 1'b0;
         end
         default: begin
         end
      endcase

      // An event is held back until the next one, or the end of the walk, shows whether it is last.
      if (changed) begin
         touched_in[rd_idx_ff] = now_touched;
         if (pend_vld_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_ev_in   = pend_ev_ff;
            rsp_idx_in  = pend_idx_ff;
            rsp_last_in = 1'b0;
         end
         pend_vld_in = 1'b1;
         pend_ev_in  = now_touched ? EV_PRESSED : EV_RELEASED;
         pend_idx_in = rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         used_ff     <= '0;
         touched_ff  <= '0;
         rd_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         used_ff     <= used_in;
         touched_ff  <= touched_in;
         rd_vld_ff   <= rd_vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rd_idx_ff   <= idx_ff;
      pend_ev_ff  <= pend_ev_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= mem_wdata;
      end
      rd_q_ff <= mem[idx_ff];
   end

   assign slot_ext      = {{SLOT_W{1'b0}}, rsp_idx_ff};
   assign rsp_valid     = rsp_vld_ff;
   assign rsp_event_res = rsp_ev_ff;
   assign rsp_slot      = slot_ext[SLOT_W-1:0];
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/touch_button_event_table_unit.sv -----
// Top level of the touch button event table: front end, command queue and back end.
//
// An item is transferred on the request channel at a rising edge where start is high
// and busy is low. Action add places a button in the lowest free slot, sample tests a
// touch point against every button in use, clear frees every slot; action code three
// is taken and dropped. Accepted items wait in a two-entry queue, so busy rises only
// when that queue is full while the back end is still working.
// Each result is shown for one cycle with rsp_valid high; the receiver cannot stall.
// The back end walks the table one slot per cycle; an add stops at the first free slot
// or at the last slot. A sample walks every slot, the edge memory read being
// registered; each event is shown once the following change, or the end of the walk,
// is known, and the final one carries rsp_last. A clear is carried out as the back
// end takes it from the queue, without a walk.
// Reset empties the queue and the table and drops any walk in progress.
`default_nettype none

module touch_button_event_table_unit
   import tbet_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [COORD_W-1:0]   req_pos_x,
   input  wire logic [COORD_W-1:0]   req_pos_y,
   input  wire logic [COORD_W-1:0]   req_width,
   input  wire logic [COORD_W-1:0]   req_height,
   input  wire logic                 req_touching,
   output logic                      rsp_valid,
   output logic [EVENT_W-1:0]        rsp_event_res,
   output logic [SLOT_W-1:0]         rsp_slot,
   output logic                      rsp_last
);

   logic     q_valid;
   cmd_type  q_cmd;
   logic     q_pop;

   tbet_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_width    (req_width),
      .req_height   (req_height),
      .req_touching (req_touching),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .q_pop        (q_pop)
   );

   tbet_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_event_res (rsp_event_res),
      .rsp_slot      (rsp_slot),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

// ----- sim/touch_button_event_table_checker.sv -----
// Checker that predicts and compares the events of the touch button event table.
`timescale 1ns / 1ps

module touch_button_event_table_checker
   import tbet_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [COORD_W-1:0]  req_pos_x,
   input  logic [COORD_W-1:0]  req_pos_y,
   input  logic [COORD_W-1:0]  req_width,
   input  logic [COORD_W-1:0]  req_height,
   input  logic                req_touching,
   input  logic                rsp_valid,
   input  logic [EVENT_W-1:0]  rsp_event_res,
   input  logic [SLOT_W-1:0]   rsp_slot,
   input  logic                rsp_last,
   output int                  fail_count,
   output int                  pending_count,
   output int                  result_count
);

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [SLOT_W-1:0]  slot;
      logic               last;
   } touch_event_type;

   touch_event_type    expected_events[$];
   logic               btn_used[SLOTS];
   logic               btn_pressed[SLOTS];
   logic [COORD_W-1:0] btn_left[SLOTS];
   logic [COORD_W-1:0] btn_top[SLOTS];
   logic [EDGE_W-1:0]  btn_right[SLOTS];
   logic [EDGE_W-1:0]  btn_bottom[SLOTS];
   int                 fails = 0;
   int                 results = 0;

   task report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      fails++;
   endtask

   task predict_transfer(input logic [ACTION_W-1:0] action, input logic [COORD_W-1:0] x,
                         input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] w,
                         input logic [COORD_W-1:0] h, input logic touch);
      int              first_free;
      logic            hit;
      logic            have_held;
      touch_event_type held;
      first_free = -1;
      have_held  = 1'b0;
      held       = '0;
      case (action)
         ACT_ADD: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!btn_used[i] && first_free < 0) first_free = i;
            end
            if (first_free >= 0) begin
               btn_used[first_free]    = 1'b1;
               btn_pressed[first_free] = 1'b0;
               btn_left[first_free]    = x;
               btn_top[first_free]     = y;
               btn_right[first_free]   = {1'b0, x} + {1'b0, w};
               btn_bottom[first_free]  = {1'b0, y} + {1'b0, h};
               expected_events.push_back({EV_ADDED, SLOT_W'(first_free), 1'b1});
            end else begin
               expected_events.push_back({EV_FULL, SLOT_W'(0), 1'b1});
            end
         end
         ACT_SAMPLE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (btn_used[i]) begin
                  hit = touch && (x > btn_left[i]) && ({1'b0, x} < btn_right[i])
                        && (y > btn_top[i]) && ({1'b0, y} < btn_bottom[i]);
                  if (hit != btn_pressed[i]) begin
                     if (have_held) expected_events.push_back(held);
                     held      = {hit ? EV_PRESSED : EV_RELEASED, SLOT_W'(i), 1'b0};
                     have_held = 1'b1;
                  end
                  btn_pressed[i] = hit;
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               expected_events.push_back(held);
            end
         end
         ACT_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               btn_used[i]    = 1'b0;
               btn_pressed[i] = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      touch_event_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            btn_used[i]    = 1'b0;
            btn_pressed[i] = 1'b0;
         end
         expected_events.delete();
      end else begin
         if (rsp_valid !== 1'b0) begin
            results++;
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event %0d slot %0d last %0b",
                                         rsp_event_res, rsp_slot, rsp_last));
            end else begin
               want = expected_events.pop_front();
               if (rsp_valid !== 1'b1)
                  report_mismatch("result strobe is unknown");
               if (rsp_event_res !== want.event_res)
                  report_mismatch($sformatf("event %0d, wanted %0d", rsp_event_res,
                                            want.event_res));
               if (rsp_slot !== want.slot)
                  report_mismatch($sformatf("slot %0d, wanted %0d", rsp_slot, want.slot));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, wanted %0b", rsp_last, want.last));
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            predict_transfer(req_action, req_pos_x, req_pos_y, req_width, req_height,
                             req_touching);
         else if (start === 1'b1 && busy !== 1'b1)
            report_mismatch("busy is unknown while start is high");
      end
      fail_count    <= fails;
      pending_count <= expected_events.size();
      result_count  <= results;
   end

endmodule

// ----- sim/testbench.sv -----
// Top of the touch button event table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench
   import tbet_pkg::*;
;

   localparam int SLOTS         = 16;
   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int ITEM_COUNT    = 210;
   localparam int MAX_GAP       = 16;
   localparam int DRAIN_CYCLES  = 3 * (SLOTS + 3) + 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int COORD_MAX     = (1 << COORD_W) - 1;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                start        = 1'b0;
   logic [ACTION_W-1:0] req_action   = '0;
   logic [COORD_W-1:0]  req_pos_x    = '0;
   logic [COORD_W-1:0]  req_pos_y    = '0;
   logic [COORD_W-1:0]  req_width    = '0;
   logic [COORD_W-1:0]  req_height   = '0;
   logic                req_touching = 1'b0;
   logic                busy;
   logic                rsp_valid;
   logic [EVENT_W-1:0]  rsp_event_res;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_last;
   int                  fail_count;
   int                  pending_count;
   int                  result_count;

   int  cycle_count   = 0;
   int  items_sent    = 0;
   int  directed_items;
   bit  no_idle       = 1'b0;
   int  scene_n       = 0;
   int  scene_left[SLOTS];
   int  scene_top[SLOTS];
   int  scene_w[SLOTS];
   int  scene_h[SLOTS];

   touch_button_event_table_unit #(.SLOTS(SLOTS)) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_width     (req_width),
      .req_height    (req_height),
      .req_touching  (req_touching),
      .rsp_valid     (rsp_valid),
      .rsp_event_res (rsp_event_res),
      .rsp_slot      (rsp_slot),
      .rsp_last      (rsp_last)
   );

   touch_button_event_table_checker #(.SLOTS(SLOTS)) event_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_width     (req_width),
      .req_height    (req_height),
      .req_touching  (req_touching),
      .rsp_valid     (rsp_valid),
      .rsp_event_res (rsp_event_res),
      .rsp_slot      (rsp_slot),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d events outstanding", cycle_count,
                  pending_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   function int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   task send_item(input logic [ACTION_W-1:0] action, input int x, input int y, input int w,
                  input int h, input logic touch);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        <= 1'b1;
      req_action   <= action;
      req_pos_x    <= COORD_W'(x);
      req_pos_y    <= COORD_W'(y);
      req_width    <= COORD_W'(w);
      req_height   <= COORD_W'(h);
      req_touching <= touch;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
   endtask

   task add_button(input int x, input int y, input int w, input int h);
      send_item(ACT_ADD, x, y, w, h, 1'($urandom_range(0, 1)));
      if (scene_n < SLOTS) begin
         scene_left[scene_n] = x;
         scene_top[scene_n]  = y;
         scene_w[scene_n]    = w;
         scene_h[scene_n]    = h;
         scene_n++;
      end
   endtask

   function int near_edge(input int lo, input int span);
      case ($urandom_range(0, 5))
         0: return clamp_coord(lo);
         1: return clamp_coord(lo + 1);
         2: return clamp_coord(lo + span - 1);
         3: return clamp_coord(lo + span);
         default: return clamp_coord(lo + $urandom_range(0, span));
      endcase
   endfunction

   task touch_sample();
      int   k;
      int   x;
      int   y;
      logic touch;
      touch = ($urandom_range(0, 3) != 0);
      if (scene_n > 0 && $urandom_range(0, 3) != 0) begin
         k = $urandom_range(0, scene_n - 1);
         x = near_edge(scene_left[k], scene_w[k]);
         y = near_edge(scene_top[k], scene_h[k]);
      end else begin
         x = $urandom_range(0, COORD_MAX);
         y = $urandom_range(0, COORD_MAX);
      end
      send_item(ACT_SAMPLE, x, y, $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), touch);
   endtask

   task clear_table();
      send_item(ACT_CLEAR, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                1'($urandom_range(0, 1)));
      scene_n = 0;
   endtask

   task run_scene();
      int n_add;
      int n_touch;
      int rx;
      int ry;
      int w;
      int h;
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 2) begin
         repeat ($urandom_range(1, 4)) begin
            send_item(ACTION_W'($urandom_range(0, 3)), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), 1'($urandom_range(0, 1)));
         end
         scene_n = 0;
      end else begin
         if ($urandom_range(0, 2) != 0) clear_table();
         n_add = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 6);
         rx = $urandom_range(0, 3900);
         ry = $urandom_range(0, 3900);
         repeat (n_add) begin
            if ($urandom_range(0, 7) == 0) begin
               w = $urandom_range(0, COORD_MAX);
               h = $urandom_range(0, COORD_MAX);
            end else begin
               w = $urandom_range(0, 300);
               h = $urandom_range(0, 300);
            end
            add_button(rx + $urandom_range(0, 150), ry + $urandom_range(0, 150), w, h);
         end
         n_touch = $urandom_range(2, 10);
         repeat (n_touch) touch_sample();
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty table, size extremes, strict edges, a full table.
      send_item(ACT_SAMPLE, 10, 10, 0, 0, 1'b1);
      send_item(ACT_ADD, 0, 0, 0, 0, 1'b0);
      send_item(ACT_ADD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      send_item(ACT_ADD, 100, 100, 200, 50, 1'b0);
      send_item(ACT_SAMPLE, 150, 120, 0, 0, 1'b1);
      send_item(ACT_SAMPLE, 150, 120, 0, 0, 1'b1);
      send_item(ACT_SAMPLE, 150, 120, 0, 0, 1'b0);
      send_item(ACT_SAMPLE, 100, 120, 0, 0, 1'b1);
      send_item(ACT_SAMPLE, 299, 149, 0, 0, 1'b1);
      send_item(ACT_SAMPLE, 300, 149, 0, 0, 1'b1);
      send_item(ACT_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      for (int i = 0; i < SLOTS - 3; i++) send_item(ACT_ADD, 1000 + i, 1000, 2000, 2000, 1'b0);
      send_item(ACT_ADD, 5, 5, 5, 5, 1'b0);
      send_item(ACT_SAMPLE, 2000, 2000, 0, 0, 1'b1);
      send_item(ACT_SAMPLE, 2000, 2000, 0, 0, 1'b0);
      send_item(ACT_CLEAR, 0, 0, 0, 0, 1'b0);
      send_item(ACT_ADD, 1, 2, 3, 4, 1'b0);
      directed_items = items_sent;

      while (items_sent < ITEM_COUNT) run_scene();

      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transfers (%0d directed) and checked %0d events in %0d cycles,",
               items_sent, directed_items, result_count, cycle_count);
      $display("with adds to a full table, clears, strict edge touches and idle gaps.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/tbet_pkg.sv
hw/rtl/tbet_front.sv
hw/rtl/tbet_back.sv
hw/rtl/touch_button_event_table_unit.sv
sim/touch_button_event_table_checker.sv
sim/testbench.sv
